@@ design/cube_to_sphere_map_macros.svh @@
// ----------------------------------------------------------------------------
// cube_to_sphere_map_macros.svh
// Assertion helpers shared by the cube-to-sphere mapping design. The
// expanding module provides clk_i, rst_ni and LATENCY.
// ----------------------------------------------------------------------------
`ifndef CUBE_TO_SPHERE_MAP_MACROS_SVH
`define CUBE_TO_SPHERE_MAP_MACROS_SVH

// Check a property on every rising edge outside reset.
`define C2S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that an accepted word with a given cause shows the effect at the output.
`define C2S_ASSERT_LAT(lbl, cause, effect, msg) \
  `C2S_ASSERT(lbl, (cause) |-> ##LATENCY (effect), msg)

`endif

@@ design/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Widths, pipeline depths and shared types of the cube-to-sphere mapping.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FIELD_W    = 18;
  localparam int LANES      = 3;

  localparam int MAG_W      = FRAC_BITS + 1;
  localparam int SQ_W       = 2 * FRAC_BITS + 1;
  localparam int HALF_W     = 2 * FRAC_BITS;
  localparam int T_W        = 2 * FRAC_BITS;
  localparam int PLO_W      = SQ_W + 2 * FRAC_BITS;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam logic [MAG_W-1:0] MAG_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // floor(n / 3) = (n * DIV3_MUL) >> DIV3_SHIFT for n <= 2^(2*FRAC_BITS);
  // DIV3_MUL = 2^(2*FRAC_BITS) + DIV3_LO.
  localparam int DIV3_SHIFT = 2 * FRAC_BITS + 2;
  localparam logic [63:0] DIV3_MUL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [2*FRAC_BITS-1:0] DIV3_LO = DIV3_MUL[2*FRAC_BITS-1:0];

  localparam int SQRT_ITERS  = FRAC_BITS + 1;
  localparam int SQRT_STAGES = (SQRT_ITERS + 1) / 2;
  localparam int PRE_STAGES  = 6;
  localparam int LATENCY     = PRE_STAGES + SQRT_STAGES + 2;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } lane_side_t;

endpackage

@@ design/cube_to_sphere_map.sv @@
// ----------------------------------------------------------------------------
// cube_to_sphere_map
// Maps a point on the unit cube surface to the unit sphere, signed Q1.16.
// ----------------------------------------------------------------------------
// A word is taken on every clock with start high; busy never rises, and
// the mapped point appears on the sphere ports with done_o high, one
// result per clock. The pipeline is the 17-bit square root, resolved two
// bits per stage over nine stages, plus six stages of squaring, product
// and divide-by-three ahead of it and two stages of scaling and sign after
// it. The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
`include "cube_to_sphere_map_macros.svh"

module cube_to_sphere_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [c2s_pkg::FIELD_W-1:0]  cube_x_i,
  input  logic signed [c2s_pkg::FIELD_W-1:0]  cube_y_i,
  input  logic signed [c2s_pkg::FIELD_W-1:0]  cube_z_i,
  output logic                                done_o,
  output logic signed [c2s_pkg::FIELD_W-1:0]  sphere_x_o,
  output logic signed [c2s_pkg::FIELD_W-1:0]  sphere_y_o,
  output logic signed [c2s_pkg::FIELD_W-1:0]  sphere_z_o
);
  import c2s_pkg::*;

  localparam logic [SQ_W:0] ONE_SQ = {2'b01, {(2 * FRAC_BITS){1'b0}}};

  logic                     accept;
  logic signed [FIELD_W-1:0] cube_in [LANES];

  logic [PRE_STAGES-1:0]    pre_valid_q;
  lane_side_t               side_d  [LANES];
  lane_side_t               side_q  [PRE_STAGES][LANES];

  logic [SQ_W-1:0]          sq_q    [LANES];
  logic [SQ_W-1:0]          prod_q  [LANES];
  logic [SQ_W-1:0]          hsum_q  [LANES];
  logic [PLO_W-1:0]         plo_q   [LANES];
  logic [SQ_W-1:0]          prod4_q [LANES];
  logic [SQ_W-1:0]          hsum4_q [LANES];
  logic [T_W-1:0]           t_q     [LANES];
  logic [SQ_W-1:0]          hsum5_q [LANES];
  logic [SQ_W-1:0]          rad_q   [LANES];

  logic                     root_valid;
  logic [MAG_W-1:0]         root    [LANES];
  lane_side_t               root_side [LANES];

  logic                     mul_valid_q;
  logic [MAG_W-1:0]         mag_q   [LANES];
  logic                     neg_q   [LANES];
  logic                     out_valid_q;
  logic [FIELD_W-1:0]       sphere_q [LANES];

  logic                     unit_ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cube_in[0] = cube_x_i;
  assign cube_in[1] = cube_y_i;
  assign cube_in[2] = cube_z_i;

  always_comb begin
    logic [FIELD_W:0] ext;
    logic [FIELD_W:0] abs_v;
    for (int l = 0; l < LANES; l++) begin
      ext   = {cube_in[l][FIELD_W-1], cube_in[l]};
      abs_v = ext[FIELD_W] ? (~ext + 1'b1) : ext;
      side_d[l].neg = ext[FIELD_W];
      side_d[l].mag = (abs_v > (FIELD_W + 1)'(ONE)) ? MAG_ONE : abs_v[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= '0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pre_valid_q <= {pre_valid_q[PRE_STAGES-2:0], accept};
      mul_valid_q <= root_valid;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      side_q[0] <= side_d;
    end
    for (int s = 1; s < PRE_STAGES; s++) begin
      if (pre_valid_q[s-1]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam int LA = (l + 1) % LANES;
    localparam int LB = (l + 2) % LANES;

    logic [2*MAG_W-1:0] sq_full;
    logic [2*MAG_W-1:0] prod_full;
    logic [SQ_W-1:0]    hsum_d;
    logic [PLO_W-1:0]   plo_d;
    logic [PLO_W:0]     div_sum;
    logic [SQ_W:0]      rad_full;
    logic [2*MAG_W-1:0] scale_full;
    logic [FIELD_W-1:0] mag_ext;

    assign sq_full   = side_q[0][l].mag * side_q[0][l].mag;
    assign prod_full = sq_q[LA][SQ_W-1:FRAC_BITS] * sq_q[LB][SQ_W-1:FRAC_BITS];
    assign hsum_d    = {1'b0, sq_q[LA][SQ_W-1:1]} + {1'b0, sq_q[LB][SQ_W-1:1]};
    assign plo_d     = prod_q[l] * DIV3_LO;
    assign div_sum   = {1'b0, plo_q[l]} + {1'b0, prod4_q[l], {HALF_W{1'b0}}};
    assign rad_full  = ONE_SQ + (SQ_W + 1)'(t_q[l]) - (SQ_W + 1)'(hsum5_q[l]);
    assign scale_full = root_side[l].mag * root[l];
    assign mag_ext   = FIELD_W'(mag_q[l]);

    always_ff @(posedge clk_i) begin
      if (pre_valid_q[0]) begin
        sq_q[l] <= sq_full[SQ_W-1:0];
      end
      if (pre_valid_q[1]) begin
        prod_q[l] <= prod_full[SQ_W-1:0];
        hsum_q[l] <= hsum_d;
      end
      if (pre_valid_q[2]) begin
        plo_q[l]   <= plo_d;
        prod4_q[l] <= prod_q[l];
        hsum4_q[l] <= hsum_q[l];
      end
      if (pre_valid_q[3]) begin
        t_q[l]     <= div_sum[PLO_W:DIV3_SHIFT];
        hsum5_q[l] <= hsum4_q[l];
      end
      if (pre_valid_q[4]) begin
        rad_q[l] <= rad_full[SQ_W-1:0];
      end
      if (root_valid) begin
        mag_q[l] <= scale_full[FRAC_BITS+MAG_W-1:FRAC_BITS];
        neg_q[l] <= root_side[l].neg;
      end
      if (mul_valid_q) begin
        sphere_q[l] <= neg_q[l] ? (~mag_ext + 1'b1) : mag_ext;
      end
    end
  end

  c2s_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pre_valid_q[PRE_STAGES-1]),
    .rad_i   (rad_q),
    .side_i  (side_q[PRE_STAGES-1]),
    .valid_o (root_valid),
    .root_o  (root),
    .side_o  (root_side)
  );

  assign done_o     = out_valid_q;
  assign sphere_x_o = sphere_q[0];
  assign sphere_y_o = sphere_q[1];
  assign sphere_z_o = sphere_q[2];

  assign unit_ok = sphere_x_o <= ONE && sphere_x_o >= -ONE &&
                   sphere_y_o <= ONE && sphere_y_o >= -ONE &&
                   sphere_z_o <= ONE && sphere_z_o >= -ONE;

  `C2S_ASSERT_LAT(a_fixed_latency, accept, done_o, "accepted word did not come out on time")
  `C2S_ASSERT(a_no_spurious, done_o |-> $past(accept, LATENCY), "result without a word in")
  `C2S_ASSERT(a_unit_range, done_o |-> unit_ok, "sphere point beyond unit range")
  `C2S_ASSERT_LAT(a_zero_keeps_zero, accept && cube_x_i == '0, sphere_x_o == '0, "zero x kept")

endmodule

@@ design/c2s_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// c2s_sqrt_pipe
// Pipelined integer square root for three lanes, two root bits per stage,
// with per-lane side data carried alongside.
// ----------------------------------------------------------------------------
module c2s_sqrt_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [c2s_pkg::SQ_W-1:0]    rad_i  [c2s_pkg::LANES],
  input  c2s_pkg::lane_side_t         side_i [c2s_pkg::LANES],
  output logic                        valid_o,
  output logic [c2s_pkg::MAG_W-1:0]   root_o [c2s_pkg::LANES],
  output c2s_pkg::lane_side_t         side_o [c2s_pkg::LANES]
);
  import c2s_pkg::*;

  localparam int RES_W = SQ_W + 1;

  typedef struct packed {
    logic [SQ_W-1:0]  rem;
    logic [RES_W-1:0] res;
  } acc_t;

  function automatic logic [RES_W-1:0] sqrt_probe(input int k);
    return {{(RES_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 2 * k);
  endfunction

  function automatic acc_t sqrt_step(input acc_t a, input logic [RES_W-1:0] probe);
    acc_t             o;
    logic [RES_W-1:0] trial;
    trial = a.res + probe;
    if ({1'b0, a.rem} >= trial) begin
      o.rem = a.rem - trial[SQ_W-1:0];
      o.res = (a.res >> 1) + probe;
    end else begin
      o.rem = a.rem;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  logic [SQRT_STAGES-1:0] valid_q;
  acc_t                   acc_q  [SQRT_STAGES][LANES];
  lane_side_t             side_q [SQRT_STAGES][LANES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic       valid_in;
    acc_t       acc_in  [LANES];
    lane_side_t side_in [LANES];
    acc_t       acc_d   [LANES];

    if (g == 0) begin : g_head
      assign valid_in = valid_i;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign acc_in[l]  = '{rem: rad_i[l], res: '0};
        assign side_in[l] = side_i[l];
      end
    end else begin : g_body
      assign valid_in = valid_q[g-1];
      assign acc_in   = acc_q[g-1];
      assign side_in  = side_q[g-1];
    end

    always_comb begin
      acc_t a;
      for (int l = 0; l < LANES; l++) begin
        a = acc_in[l];
        for (int j = 0; j < 2; j++) begin
          if (2 * g + j < SQRT_ITERS) begin
            a = sqrt_step(a, sqrt_probe(2 * g + j));
          end
        end
        acc_d[l] = a;
      end
    end

    always_ff @(posedge clk_i) begin
      if (valid_in) begin
        acc_q[g]  <= acc_d;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign side_o  = side_q[SQRT_STAGES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_root
    assign root_o[l] = acc_q[SQRT_STAGES-1][l].res[MAG_W-1:0];
  end

endmodule

@@ dv/cube_to_sphere_map_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_to_sphere_map_tb
// Drives cube points into the mapper and compares every sphere point with a
// bit-exact fixed-point prediction made when the word is taken. Sender idling
// varies by phase, the sender drains the pipeline between phases, and the
// stimulus mixes cube-face points, in-range triples, corner values and raw
// 18-bit patterns that exercise saturation.
// ----------------------------------------------------------------------------
module cube_to_sphere_map_tb;

  localparam int W = c2s_pkg::FIELD_W;
  localparam int F = c2s_pkg::FRAC_BITS;
  localparam int UNIT = c2s_pkg::ONE;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [W-1:0] cube_x_i = '0;
  logic signed [W-1:0] cube_y_i = '0;
  logic signed [W-1:0] cube_z_i = '0;
  logic done_o;
  logic signed [W-1:0] sphere_x_o;
  logic signed [W-1:0] sphere_y_o;
  logic signed [W-1:0] sphere_z_o;

  point_t cube_words_q[$];
  point_t sphere_expect_q[$];
  int idle_pct = 0;
  int mismatch_cnt = 0;

  cube_to_sphere_map i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cube_x_i   (cube_x_i),
    .cube_y_i   (cube_y_i),
    .cube_z_i   (cube_z_i),
    .done_o     (done_o),
    .sphere_x_o (sphere_x_o),
    .sphere_y_o (sphere_y_o),
    .sphere_z_o (sphere_z_o)
  );

  function automatic longint clamp_unit(logic signed [W-1:0] raw);
    longint v;
    v = raw;
    if (v > UNIT) v = UNIT;
    if (v < -UNIT) v = -UNIT;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned acc;
    longint unsigned probe;
    acc = 0;
    for (int i = 19; i >= 0; i--) begin
      probe = acc | (64'd1 << i);
      if (probe * probe <= n) acc = probe;
    end
    return acc;
  endfunction

  // scale c by sqrt(1 - a^2/2 - b^2/2 + a^2 b^2 / 3), all in Q.F
  function automatic logic [W-1:0] sphere_lane(longint c, longint a, longint b);
    longint unsigned ma, mb, mc, sa, sb, qa, qb, third, rad, root, m;
    longint o;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    mc = (c < 0) ? -c : c;
    sa = ma * ma;
    sb = mb * mb;
    qa = sa >> F;
    qb = sb >> F;
    third = (qa * qb) / 3;
    rad = (64'd1 << (2 * F)) - (sa >> 1) - (sb >> 1) + third;
    root = floor_root(rad);
    m = (mc * root) >> F;
    o = (c < 0) ? -longint'(m) : longint'(m);
    return o[W-1:0];
  endfunction

  function automatic point_t map_to_sphere(point_t p);
    longint x, y, z;
    point_t r;
    x = clamp_unit(p.x);
    y = clamp_unit(p.y);
    z = clamp_unit(p.z);
    r.x = sphere_lane(x, y, z);
    r.y = sphere_lane(y, z, x);
    r.z = sphere_lane(z, x, y);
    return r;
  endfunction

  function automatic logic signed [W-1:0] edge_value();
    case ($urandom_range(6))
      0: return '0;
      1: return 18'sd1;
      2: return -18'sd1;
      3: return 18'sd65535;
      4: return -18'sd65535;
      5: return 18'sd65536;
      default: return -18'sd65536;
    endcase
  endfunction

  function automatic logic signed [W-1:0] in_range_value();
    return W'(int'($urandom_range(2 * UNIT)) - UNIT);
  endfunction

  function automatic point_t random_point();
    point_t p;
    int pick;
    pick = $urandom_range(99);
    p.x = in_range_value();
    p.y = in_range_value();
    p.z = in_range_value();
    if (pick < 55) begin
      // pin one axis to a cube face
      case ($urandom_range(2))
        0: p.x = $urandom_range(1) ? W'(UNIT) : W'(-UNIT);
        1: p.y = $urandom_range(1) ? W'(UNIT) : W'(-UNIT);
        default: p.z = $urandom_range(1) ? W'(UNIT) : W'(-UNIT);
      endcase
    end else if (pick < 70) begin
      if ($urandom_range(1)) p.x = edge_value();
      if ($urandom_range(1)) p.y = edge_value();
      if ($urandom_range(1)) p.z = edge_value();
    end else if (pick < 85) begin
      p.x = W'($urandom());
      p.y = W'($urandom());
      p.z = W'($urandom());
    end
    return p;
  endfunction

  task automatic add_word(int x, int y, int z);
    point_t p;
    p.x = W'(x);
    p.y = W'(y);
    p.z = W'(z);
    cube_words_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [W-1:0] exp, logic [W-1:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
               $signed(exp), $signed(act));
      mismatch_cnt++;
    end
  endtask

  task automatic wait_drained();
    while (cube_words_q.size() != 0 || start) @(negedge clk_i);
    while (sphere_expect_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : drive_words
    point_t w;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) sphere_expect_q.push_back(map_to_sphere({cube_x_i, cube_y_i, cube_z_i}));
      if (!start || !busy) begin
        if (cube_words_q.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
          w = cube_words_q.pop_front();
          start <= 1'b1;
          cube_x_i <= w.x;
          cube_y_i <= w.y;
          cube_z_i <= w.z;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    point_t exp;
    if (rst_ni && done_o) begin
      if (sphere_expect_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d %0d %0d", $time,
                 sphere_x_o, sphere_y_o, sphere_z_o);
        mismatch_cnt++;
      end else begin
        exp = sphere_expect_q.pop_front();
        check_field("sphere_x", exp.x, sphere_x_o);
        check_field("sphere_y", exp.y, sphere_y_o);
        check_field("sphere_z", exp.z, sphere_z_o);
      end
    end
  end

  initial begin
    #2000000;
    $display("cube_to_sphere_map_tb: FAIL");
    $finish;
  end

  initial begin
    int phase_idle[4];
    phase_idle = '{0, 88, 0, 14};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_word(0, 0, 0);
    add_word(UNIT, 0, 0);
    add_word(-UNIT, 0, 0);
    add_word(0, UNIT, 0);
    add_word(0, -UNIT, 0);
    add_word(0, 0, UNIT);
    add_word(0, 0, -UNIT);
    add_word(UNIT, UNIT, UNIT);
    add_word(-UNIT, -UNIT, -UNIT);
    add_word(UNIT, -UNIT, UNIT);
    add_word(131071, -131072, 65537);
    add_word(-65537, 131071, -131072);
    add_word(-131072, -131072, -131072);
    add_word(131071, 131071, 131071);
    add_word(1, -1, UNIT);
    add_word(UNIT, 1, -1);
    add_word(UNIT, 32768, -32768);
    add_word(-49152, UNIT, 16384);
    add_word(65535, -65535, -UNIT);
    add_word(UNIT, 0, 40000);
    wait_drained();

    foreach (phase_idle[i]) begin
      idle_pct = phase_idle[i];
      repeat (275) cube_words_q.push_back(random_point());
      // hold until the pipeline is empty before the next phase
      wait_drained();
    end

    repeat (c2s_pkg::LATENCY + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("cube_to_sphere_map_tb: PASS");
    end else begin
      $display("cube_to_sphere_map_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ cube_to_sphere_map.f @@
+incdir+design
design/c2s_pkg.sv
design/c2s_sqrt_pipe.sv
design/cube_to_sphere_map.sv
dv/cube_to_sphere_map_tb.sv
